// File: rtl/core/hmi_command_deframer_assert.svh
// Assertion macros for the command deframer.
`ifndef HMI_COMMAND_DEFRAMER_ASSERT_SVH
`define HMI_COMMAND_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check an expression at every clock edge out of reset.
`define HCD_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("hcd assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define HCD_ASSERT_IMPL(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("hcd assertion failed");
`else
`define HCD_ASSERT(label, expr)
`define HCD_ASSERT_IMPL(label, cond, cons)
`endif

`endif

// File: rtl/core/hcd_pkg.sv
// Shared types and constants of the command deframer.
package hcd_pkg;

  localparam int unsigned POS_WIDTH_DEF = 10;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned OUT_POS_W     = 10;
  localparam int unsigned MAX_LEN_W     = 10;
  localparam int unsigned EXP_W         = 9;
  localparam int unsigned LEN_BIAS      = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned QUEUE_DEPTH   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_WORD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_WORD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 3'd4;

  localparam logic        MODE_TAIL   = 1'b0;
  localparam logic        MODE_LENGTH = 1'b1;

  localparam logic [7:0]  HEAD_BYTE_RST = 8'hEE;
  localparam logic [31:0] TAIL_WORD_RST = 32'hFFFC_FFFF;
  localparam logic [15:0] HEAD_WORD_RST = 16'h5AA5;
  localparam logic [9:0]  MAX_LEN_RST   = 10'd258;

  typedef struct packed {
    logic        frame_mode;
    logic [7:0]  head_byte;
    logic [31:0] tail_word;
    logic [15:0] head_word;
    logic [9:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [9:0]  position;
    logic        stored;
    logic        frame_end;
    logic [9:0]  frame_length;
    logic        last_of_run;
  } res_t;

endpackage

// File: rtl/core/hmi_command_deframer.sv
// Top level of the command deframer: config registers and result queue.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-------------------------------------------
//  in_     | in  | in_tvalid / in_tready   | tdata: rx_byte
//  out_    | out | out_tvalid / out_tready | tdata: data_byte, position, frame_length
//          |     |                         | tuser: stored, frame_end; tlast: last_of_run
//  cfg_    | in  | cfg_we                  | cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_tready is high and is decoded in the cycle it is
// accepted; results go to a three-entry result queue, read one per cycle on out_tready.
// A byte that opens a length-mode frame yields two results, so a run of them is
// limited by the single-result output port.
// in_tready is high while at least two queue entries are free after this cycle's pop.
// Synchronous active-low reset clears frame state and queue count and loads the
// config register defaults.
module hmi_command_deframer import hcd_pkg::*; #(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [7:0] data_byte, [17:8] position,
                                            // [27:18] frame_length, [31:28] zero
  output logic [1:0]            out_tuser,  // [0] stored, [1] frame_end
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  res_t       q_r [QUEUE_DEPTH];
  res_t       q_nxt [QUEUE_DEPTH];
  res_t       q_sh [QUEUE_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] base;
  logic [1:0] res_cnt;
  res_t       res0, res1;
  logic       pop, acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_mode <= MODE_TAIL;
      cfg_r.head_byte  <= HEAD_BYTE_RST;
      cfg_r.tail_word  <= TAIL_WORD_RST;
      cfg_r.head_word  <= HEAD_WORD_RST;
      cfg_r.max_len    <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_MODE: cfg_r.frame_mode <= cfg_wdata[0];
        REG_HEAD_BYTE:  cfg_r.head_byte  <= cfg_wdata[7:0];
        REG_TAIL_WORD:  cfg_r.tail_word  <= cfg_wdata[31:0];
        REG_HEAD_WORD:  cfg_r.head_word  <= cfg_wdata[15:0];
        REG_MAX_LEN:    cfg_r.max_len    <= cfg_wdata[MAX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign base       = cnt_r - {1'b0, pop};
  assign in_tready  = (base <= 2'd1);
  assign acc        = in_tvalid && in_tready;

  hcd_frame_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .acc     (acc),
    .rx_byte (in_tdata),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  always_comb begin
    // Advance the queue on a pop, then append this item's results behind it.
    q_sh[0] = pop ? q_r[1] : q_r[0];
    q_sh[1] = pop ? q_r[2] : q_r[1];
    q_sh[2] = q_r[2];
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_sh[i];
      if (acc && res_cnt != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = res0;
      end else if (acc && res_cnt == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = acc ? base + res_cnt : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_tdata = {4'd0, q_r[0].frame_length, q_r[0].position, q_r[0].data_byte};
  assign out_tuser = {q_r[0].frame_end, q_r[0].stored};
  assign out_tlast = q_r[0].last_of_run;

`include "hmi_command_deframer_assert.svh"

  `HCD_ASSERT_IMPL(a_no_overflow, acc, (3'(base) + 3'(res_cnt)) <= 3'd3)
  `HCD_ASSERT_IMPL(a_end_is_last, out_tvalid && out_tuser[1], out_tlast)
  `HCD_ASSERT_IMPL(a_head_has_follower, out_tvalid && !out_tlast, cnt_r >= 2'd2)

endmodule

// File: rtl/core/hcd_frame_core.sv
// Frame tracking state and per-byte result generation.
module hcd_frame_core import hcd_pkg::*; #(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              acc,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic [1:0]        res_cnt,
  output res_t              res0,
  output res_t              res1
);

  localparam int unsigned CW = POS_WIDTH + OUT_POS_W;

  logic [POS_WIDTH-1:0] frame_pos_r, frame_pos_nxt;
  logic [31:0]          tail_shift_r, tail_shift_nxt;
  logic [15:0]          head_shift_r, head_shift_nxt;
  logic [EXP_W-1:0]     exp_len_r, exp_len_nxt;

  function automatic logic [OUT_POS_W-1:0] low_bits(input logic [CW-1:0] v);
    return v[OUT_POS_W-1:0];
  endfunction

  logic [CW-1:0]        pos_w, max_w, p_w, fpn_w, exp_w, min_w;
  logic [POS_WIDTH-1:0] p, fpn, fp1;
  logic [31:0]          ts;
  logic [15:0]          hs;
  logic [EXP_W-1:0]     exp_sel;
  logic                 st, hit, open, done;
  res_t                 main_res, head_res;

  always_comb begin
    pos_w = CW'(frame_pos_r);
    max_w = CW'(cfg.max_len);
    ts    = {tail_shift_r[23:0], rx_byte};
    hs    = {head_shift_r[7:0], rx_byte};
    open  = (frame_pos_r == '0);

    frame_pos_nxt  = frame_pos_r;
    tail_shift_nxt = tail_shift_r;
    head_shift_nxt = head_shift_r;
    exp_len_nxt    = exp_len_r;
    res_cnt        = 2'd0;
    main_res       = '0;
    head_res       = '0;

    p       = '0;
    p_w     = '0;
    fpn     = '0;
    fpn_w   = '0;
    fp1     = '0;
    exp_sel = exp_len_r;
    exp_w   = '0;
    min_w   = '0;
    st      = 1'b0;
    hit     = 1'b0;
    done    = 1'b0;

    if (cfg.frame_mode == MODE_TAIL) begin
      // Outside a frame, drop everything but the head byte.
      st  = (pos_w < max_w);
      fp1 = st ? frame_pos_r + POS_WIDTH'(1) : frame_pos_r;
      hit = (ts == cfg.tail_word);
      main_res.data_byte    = rx_byte;
      main_res.position     = low_bits(pos_w);
      main_res.stored       = st;
      main_res.frame_end    = hit;
      main_res.frame_length = hit ? low_bits(CW'(fp1)) : '0;
      main_res.last_of_run  = 1'b1;
      if (!(open && rx_byte != cfg.head_byte)) begin
        res_cnt        = 2'd1;
        frame_pos_nxt  = hit ? '0 : fp1;
        tail_shift_nxt = hit ? '0 : ts;
      end
    end else begin
      head_shift_nxt = hs;
      p       = open ? POS_WIDTH'(1) : frame_pos_r;
      p_w     = CW'(p);
      st      = (p_w < max_w);
      fpn     = p + POS_WIDTH'(1);
      fpn_w   = CW'(fpn);
      // The byte after the head holds the payload length.
      exp_sel = (fpn_w == CW'(LEN_BIAS)) ? EXP_W'(rx_byte) + EXP_W'(LEN_BIAS) : exp_len_r;
      exp_w   = CW'(exp_sel);
      done    = (fpn_w >= exp_w);
      min_w   = (fpn_w < max_w) ? fpn_w : max_w;

      head_res.data_byte    = cfg.head_word[15:8];
      head_res.position     = '0;
      head_res.stored       = (cfg.max_len != '0);
      head_res.frame_end    = 1'b0;
      head_res.frame_length = '0;
      head_res.last_of_run  = 1'b0;

      main_res.data_byte    = rx_byte;
      main_res.position     = low_bits(p_w);
      main_res.stored       = st;
      main_res.frame_end    = done;
      main_res.frame_length = done ? low_bits(min_w) : '0;
      main_res.last_of_run  = 1'b1;

      if (!(open && hs != cfg.head_word)) begin
        res_cnt        = open ? 2'd2 : 2'd1;
        frame_pos_nxt  = done ? '0 : fpn;
        exp_len_nxt    = done ? EXP_W'(LEN_BIAS) : exp_sel;
        head_shift_nxt = done ? '0 : hs;
      end
    end

    res0 = (res_cnt == 2'd2) ? head_res : main_res;
    res1 = main_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pos_r  <= '0;
      tail_shift_r <= '0;
      head_shift_r <= '0;
      exp_len_r    <= EXP_W'(LEN_BIAS);
    end else if (acc) begin
      frame_pos_r  <= frame_pos_nxt;
      tail_shift_r <= tail_shift_nxt;
      head_shift_r <= head_shift_nxt;
      exp_len_r    <= exp_len_nxt;
    end
  end

endmodule

// File: tb/hmi_command_deframer_checker.sv
// Frame decoder model and result comparison for the command deframer.
`timescale 1ns / 100ps

module hmi_command_deframer_checker import hcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    results_due,
  output int                    results_checked,
  output int                    frames_closed
);

  cfg_t                      regs;
  logic [POS_WIDTH_DEF-1:0]  pos_cnt;
  logic [31:0]               tail_sr;
  logic [15:0]               head_sr;
  logic [EXP_W-1:0]          frame_len_due;
  res_t                      frame_results[$];
  res_t                      got;
  res_t                      want;
  int                        mismatches = 0;
  int                        n_checked = 0;
  int                        n_frames = 0;

  // Decode one accepted byte and queue the results it produces.
  task automatic deframe_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    if (regs.frame_mode == MODE_TAIL) begin
      // outside a frame only the head byte opens one
      if (pos_cnt == '0 && b != regs.head_byte) return;
      r.data_byte   = b;
      r.position    = pos_cnt;
      r.stored      = (pos_cnt < regs.max_len);
      r.last_of_run = 1'b1;
      if (r.stored) pos_cnt = pos_cnt + 1'b1;
      tail_sr = {tail_sr[23:0], b};
      if (tail_sr == regs.tail_word) begin
        r.frame_end    = 1'b1;
        r.frame_length = pos_cnt;
        tail_sr        = '0;
        pos_cnt        = '0;
      end
      frame_results.push_back(r);
    end else begin
      head_sr = {head_sr[7:0], b};
      if (pos_cnt == '0) begin
        if (head_sr != regs.head_word) return;
        // head match emits the first head byte ahead of this one
        r.data_byte = regs.head_word[15:8];
        r.stored    = (regs.max_len != '0);
        frame_results.push_back(r);
        pos_cnt = 1;
        r = '0;
      end
      r.data_byte   = b;
      r.position    = pos_cnt;
      r.stored      = (pos_cnt < regs.max_len);
      r.last_of_run = 1'b1;
      pos_cnt = pos_cnt + 1'b1;
      if (pos_cnt == LEN_BIAS) frame_len_due = EXP_W'(b) + EXP_W'(LEN_BIAS);
      if (pos_cnt >= frame_len_due) begin
        r.frame_end    = 1'b1;
        r.frame_length = (pos_cnt < regs.max_len) ? pos_cnt : regs.max_len;
        frame_len_due  = EXP_W'(LEN_BIAS);
        pos_cnt        = '0;
        head_sr        = '0;
      end
      frame_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '{frame_mode: MODE_TAIL, head_byte: HEAD_BYTE_RST, tail_word: TAIL_WORD_RST,
               head_word: HEAD_WORD_RST, max_len: MAX_LEN_RST};
      pos_cnt       = '0;
      tail_sr       = '0;
      head_sr       = '0;
      frame_len_due = EXP_W'(LEN_BIAS);
      frame_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_MODE: regs.frame_mode = cfg_wdata[0];
          REG_HEAD_BYTE:  regs.head_byte  = cfg_wdata[7:0];
          REG_TAIL_WORD:  regs.tail_word  = cfg_wdata[31:0];
          REG_HEAD_WORD:  regs.head_word  = cfg_wdata[15:0];
          REG_MAX_LEN:    regs.max_len    = cfg_wdata[MAX_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        got = '{data_byte: out_tdata[7:0], position: out_tdata[17:8],
                stored: out_tuser[0], frame_end: out_tuser[1],
                frame_length: out_tdata[27:18], last_of_run: out_tlast};
        if (frame_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none pending: byte %h pos %0d st %b end %b len %0d last %b",
                     $realtime, got.data_byte, got.position, got.stored, got.frame_end,
                     got.frame_length, got.last_of_run);
        end else begin
          want = frame_results.pop_front();
          n_checked++;
          if (got.frame_end === 1'b1) n_frames++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d mismatch", $realtime, n_checked);
              $display("  expected byte %h pos %0d st %b end %b len %0d last %b",
                       want.data_byte, want.position, want.stored, want.frame_end,
                       want.frame_length, want.last_of_run);
              $display("  actual   byte %h pos %0d st %b end %b len %0d last %b",
                       got.data_byte, got.position, got.stored, got.frame_end,
                       got.frame_length, got.last_of_run);
            end
          end
        end
      end
    end
    fail_count      <= mismatches;
    results_due     <= frame_results.size();
    results_checked <= n_checked;
    frames_closed   <= n_frames;
  end

endmodule

// File: tb/hmi_command_deframer_tb.sv
// Stimulus, clocking and verdict for the command deframer testbench.
`timescale 1ns / 100ps

module hmi_command_deframer_tb;
  import hcd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 120;
  localparam int LONG_HOLD   = 120;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int results_due;
  int results_checked;
  int frames_closed;

  // current register settings, used to build well-formed frames
  logic        cur_mode = MODE_TAIL;
  logic [7:0]  cur_head = HEAD_BYTE_RST;
  logic [31:0] cur_tail = TAIL_WORD_RST;
  logic [15:0] cur_hword = HEAD_WORD_RST;
  logic [9:0]  cur_max = MAX_LEN_RST;

  int  cycles = 0;
  int  sent_bytes = 0;
  int  phase_bytes = 0;
  int  settings_used = 1;
  int  burst_left = 0;
  bit  steady = 1'b0;
  int  hold_requests = 0;
  int  holds_done = 0;
  int  hold_left = 0;
  logic [9:0] rx_tick = '0;

  hmi_command_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  hmi_command_deframer_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .results_due     (results_due),
    .results_checked (results_checked),
    .frames_closed   (frames_closed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, results_due);
      $display("hmi_command_deframer_tb failed");
      $finish;
    end
  end

  // Receiver: a long hold on request, otherwise a stall pattern chosen by rx_tick[8:7].
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      rx_tick    <= '0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (holds_done != hold_requests) begin
        holds_done <= holds_done + 1;
        hold_left  <= LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        case (rx_tick[8:7])
          2'd0: out_tready <= 1'b1;
          2'd1: out_tready <= 1'($urandom_range(0, 1));
          2'd2: out_tready <= (rx_tick % 3 != 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sent_bytes++;
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Stop offering and wait out every pending result plus the decode pipeline.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic mode, input logic [7:0] hb, input logic [31:0] tw,
                          input logic [15:0] hw, input logic [9:0] ml);
    write_reg(REG_FRAME_MODE, CFG_DATA_W'(mode));
    write_reg(REG_HEAD_BYTE, CFG_DATA_W'(hb));
    write_reg(REG_TAIL_WORD, CFG_DATA_W'(tw));
    write_reg(REG_HEAD_WORD, CFG_DATA_W'(hw));
    write_reg(REG_MAX_LEN, CFG_DATA_W'(ml));
    cfg_we    <= 1'b0;
    cur_mode  = mode;
    cur_head  = hb;
    cur_tail  = tw;
    cur_hword = hw;
    cur_max   = ml;
    settings_used++;
  endtask

  // Head byte, random payload, tail word; now and then the tail is left off.
  task automatic tail_frame();
    int  n;
    bit  cut;
    n   = ($urandom_range(0, 7) == 0) ?
          $urandom_range(0, (cur_max < 40) ? int'(cur_max) + 6 : 60) : $urandom_range(0, 10);
    cut = ($urandom_range(0, 9) == 0);
    send_byte(cur_head);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
    if (!cut)
      for (int k = 3; k >= 0; k--) send_byte(cur_tail[k*8 +: 8]);
    phase_bytes += n + (cut ? 1 : 5);
  endtask

  // Two head bytes, length byte, payload; now and then the frame is cut short.
  task automatic length_frame();
    int  n;
    int  m;
    if ($urandom_range(0, 39) == 0)
      n = $urandom_range(0, 1) ? 255 : $urandom_range(100, 254);
    else
      n = $urandom_range(0, 12);
    send_byte(cur_hword[15:8]);
    send_byte(cur_hword[7:0]);
    if ($urandom_range(0, 9) == 0) begin
      m = $urandom_range(0, 2);
      repeat (m) send_byte(8'($urandom_range(0, 255)));
      phase_bytes += 2 + m;
    end else begin
      send_byte(8'(n));
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      phase_bytes += 3 + n;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: skipped noise, a frame closed by the default tail word
    send_bytes('{8'h00, 8'hEE, 8'h80, 8'hFF, 8'hFC, 8'hFF, 8'hFF});
    settle();
    // tail mode overflow past a two-byte buffer
    set_regs(MODE_TAIL, 8'h7E, 32'h0A0B_0C0D, HEAD_WORD_RST, 10'd2);
    send_bytes('{8'h7E, 8'h55, 8'hAA, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
    settle();
    // length mode: overflow, zero length byte, then a frame left open
    set_regs(MODE_LENGTH, 8'h7E, 32'h0A0B_0C0D, HEAD_WORD_RST, 10'd4);
    send_bytes('{8'h5A, 8'hA5, 8'h02, 8'h11, 8'h22, 8'h5A, 8'hA5, 8'h00, 8'h5A, 8'hA5});
    settle();
    // switch modes with the frame still open; tail mode picks up its position
    set_regs(MODE_TAIL, 8'h7E, 32'h0A0B_0C0D, HEAD_WORD_RST, 10'd4);
    send_bytes('{8'h01, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_regs(MODE_TAIL, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 10'd1023);
        1: set_regs(MODE_TAIL, 8'h00, 32'h0000_0000, 16'h0000, 10'd0);
        2: set_regs(MODE_LENGTH, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 10'd1023);
        3: set_regs(MODE_LENGTH, 8'h00, 32'h0000_0000, 16'h0000, 10'd0);
        default: begin
          case ($urandom_range(0, 3))
            0: cur_max = 10'($urandom_range(1, 6));
            1: cur_max = 10'($urandom_range(7, 40));
            2: cur_max = MAX_LEN_RST;
            default: cur_max = 10'($urandom_range(41, 1023));
          endcase
          set_regs(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom(),
                   16'($urandom_range(0, 65535)), cur_max);
        end
      endcase
      steady      = (ph % 4 == 2);
      phase_bytes = 0;
      // hold the receiver off while the sender keeps pushing
      if (ph == 5) hold_requests <= hold_requests + 1;
      while (phase_bytes < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        if (cur_mode == MODE_TAIL) tail_frame();
        else length_frame();
      end
      // leave a frame open across the next register change
      if ($urandom_range(0, 1)) begin
        if (cur_mode == MODE_TAIL) begin
          send_byte(cur_head);
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(cur_hword[15:8]);
          send_byte(cur_hword[7:0]);
        end
      end
      settle();
    end

    repeat (12) @(posedge clk);
    $display("Covered %0d bytes across %0d register settings, both framing modes,",
             sent_bytes, settings_used);
    $display("buffer sizes from 0 to 1023; %0d results compared, %0d frames closed.",
             results_checked, frames_closed);
    if (fail_count == 0 && results_due == 0) begin
      $display("hmi_command_deframer_tb passed");
    end else begin
      $display("hmi_command_deframer_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/hcd_pkg.sv
rtl/core/hcd_frame_core.sv
rtl/core/hmi_command_deframer.sv
tb/hmi_command_deframer_checker.sv
tb/hmi_command_deframer_tb.sv
